// ===== hdl/bbcd_pkg.sv =====
package bbcd_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int VALUE_W = 32;
    localparam int CODE_W  = 4;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 4;

    // Digit count after reset.
    localparam logic [CNT_W-1:0] DIGIT_COUNT_RESET = 4'd3;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    // Status reported by the conversion unit.
    typedef struct packed {
        logic busy;
        logic done;
    } cnv_status_t;

endpackage

// ===== hdl/bbcd_convert.sv =====
module bbcd_convert #(
    parameter int DIGITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bbcd_pkg::VALUE_W-1:0] value,
    output bbcd_pkg::cnv_status_t        status,
    output logic [DIGITS*4-1:0]          bcd
);

    localparam int BCD_W  = DIGITS * 4;
    localparam int STEP_W = $clog2(bbcd_pkg::VALUE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(bbcd_pkg::VALUE_W - 1);

    logic [bbcd_pkg::VALUE_W-1:0] bin_reg;
    logic [BCD_W-1:0]             bcd_reg;
    logic [BCD_W-1:0]             bcd_adj;
    logic [STEP_W-1:0]            step_reg;
    logic                         busy_reg;
    logic                         done_reg;

    // Add three to every digit that is five or more before the next shift.
    always_comb
    begin
        for (int k = 0; k < DIGITS; k++)
        begin
            if (bcd_reg[k*4 +: 4] >= 4'd5)
            begin
                bcd_adj[k*4 +: 4] = bcd_reg[k*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[k*4 +: 4] = bcd_reg[k*4 +: 4];
            end
        end
    end

    // Step counter and status flags; done pulses for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift one binary bit into the digit register each step. Digits that
    // overflow the top are dropped, which keeps the value modulo 10^DIGITS.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[bbcd_pkg::VALUE_W-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[bbcd_pkg::VALUE_W-1]};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

endmodule

// ===== hdl/binary_to_bcd_digit_display_driver_core.sv =====
// The first digit beat follows the conversion in the 32-step shift-and-correct
// conversion unit; an invalid digit count gives its single error beat in the
// cycle after acceptance. Then one digit beat per cycle while m_tready is high.
// A new value is taken only after the last beat for the previous one is out.
// Reset is asynchronous and active low; the digit count resets to 3.
module binary_to_bcd_digit_display_driver_core #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration: digit_count.
    input  logic                        cfg_we,
    input  logic [bbcd_pkg::CNT_W-1:0]  cfg_wdata,
    // Input stream. tdata: value[31:0].
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bbcd_pkg::VALUE_W-1:0] s_tdata,
    // Output stream. tdata: digit_code[3:0], latch_index[7:4].
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast,
    // tuser: error[0].
    output logic                        m_tuser
);

    localparam int BCD_W = MAX_DIGITS * 4;
    localparam logic [bbcd_pkg::CNT_W-1:0] MAX_CNT = bbcd_pkg::CNT_W'(MAX_DIGITS);

    bbcd_pkg::state_t            state_reg;
    bbcd_pkg::state_t            state_next;
    bbcd_pkg::cnv_status_t       cnv_status;
    logic [BCD_W-1:0]            bcd;
    logic [bbcd_pkg::CNT_W-1:0]  digit_count_reg;
    logic [bbcd_pkg::CNT_W-1:0]  pos_reg;
    logic [bbcd_pkg::CNT_W-1:0]  sel_pos;
    logic [bbcd_pkg::CODE_W-1:0] sel_code;
    logic [bbcd_pkg::CODE_W-1:0] code_reg;
    logic [bbcd_pkg::IDX_W-1:0]  idx_reg;
    logic                        last_reg;
    logic                        err_reg;
    logic                        in_beat;
    logic                        out_beat;
    logic                        count_bad;

    assign in_beat   = s_tvalid && s_tready;
    assign out_beat  = m_tvalid && m_tready;
    assign count_bad = (digit_count_reg == '0) || (digit_count_reg > MAX_CNT);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= bbcd_pkg::DIGIT_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            digit_count_reg <= cfg_wdata;
        end
    end

    // Shared conversion unit, started by each beat with a valid digit count.
    bbcd_convert #(
        .DIGITS (MAX_DIGITS)
    ) u_convert (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_beat && !count_bad),
        .value  (s_tdata),
        .status (cnv_status),
        .bcd    (bcd)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bbcd_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = count_bad ? bbcd_pkg::ST_EMIT : bbcd_pkg::ST_CONVERT;
                end
            end
            bbcd_pkg::ST_CONVERT:
            begin
                if (cnv_status.done)
                begin
                    state_next = bbcd_pkg::ST_EMIT;
                end
            end
            bbcd_pkg::ST_EMIT:
            begin
                if (out_beat && last_reg)
                begin
                    state_next = bbcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bbcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbcd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Handshake outputs.
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            bbcd_pkg::ST_IDLE:    s_tready = 1'b1;
            bbcd_pkg::ST_CONVERT: s_tready = 1'b0;
            bbcd_pkg::ST_EMIT:    m_tvalid = 1'b1;
            default:              s_tready = 1'b0;
        endcase
    end

    // Digit select: the first digit at conversion end, the next one after
    // each digit beat. Position 0 is the least significant digit.
    assign sel_pos = (state_reg == bbcd_pkg::ST_CONVERT) ? pos_reg : pos_reg - 1'b1;

    always_comb
    begin
        sel_code = '0;
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            if (sel_pos == bbcd_pkg::CNT_W'(k))
            begin
                sel_code = bcd[k*4 +: 4];
            end
        end
    end

    // Output beat registers and digit position.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            pos_reg  <= digit_count_reg - 1'b1;
            code_reg <= '0;
            idx_reg  <= '0;
            last_reg <= count_bad;
            err_reg  <= count_bad;
        end
        else if (state_reg == bbcd_pkg::ST_CONVERT && cnv_status.done)
        begin
            code_reg <= sel_code;
            idx_reg  <= '0;
            last_reg <= (pos_reg == '0);
            err_reg  <= 1'b0;
        end
        else if (out_beat && !last_reg)
        begin
            pos_reg  <= sel_pos;
            code_reg <= sel_code;
            idx_reg  <= idx_reg + 1'b1;
            last_reg <= (sel_pos == '0);
        end
    end

    assign m_tdata = {idx_reg, code_reg};
    assign m_tlast = last_reg;
    assign m_tuser = err_reg;

`ifndef NO_ASSERTIONS
    // The conversion unit only runs while the sequencer waits for it.
    a_busy_in_convert: assert property (@(posedge clk) disable iff (!rst_n)
        cnv_status.busy |-> state_reg == bbcd_pkg::ST_CONVERT)
        else $error("conversion unit busy outside the convert state");

    // An error beat is a lone, final beat with zero payload.
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'd0))
        else $error("malformed error beat");

    // Digit beats carry a decimal digit and a latch index in range.
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[3:0] <= 4'd9 && idx_reg < MAX_CNT))
        else $error("digit beat out of range");

    // No new value is taken right after one has been accepted.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("input accepted while an item is in progress");
`endif

endmodule
